// ===== rtl/stel_pkg.sv =====
// shared types and constants for the sorted table equal-range lookup
// stream field layout, command codes and sequencer state encoding
// no dependencies
package stel_pkg;

  // command codes carried in the slave-side tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // fixed field widths
  localparam int IDX_W   = 10;
  localparam int KEYF_W  = 24;
  localparam int LINK_W  = 8;
  localparam int CNTF_W  = 11;

  // slave-side tdata layout
  localparam int IN_IDX_LSB    = 0;
  localparam int IN_KEY_LSB    = IN_IDX_LSB + IDX_W;
  localparam int IN_LINK_LSB   = IN_KEY_LSB + KEYF_W;
  localparam int IN_TARGET_LSB = IN_LINK_LSB + LINK_W;
  localparam int IN_QKEY_LSB   = IN_TARGET_LSB + KEYF_W;
  localparam int IN_TDATA_W    = 96;
  localparam int IN_TUSER_W    = 1;

  // master-side tdata and tuser layout
  localparam int OUT_TDATA_W   = 32;
  localparam int OUT_TUSER_W   = 2;

  // sequencer states, one-hot
  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_LOAD     = 10'b00_0000_0010,
    ST_SEARCH   = 10'b00_0000_0100,
    ST_PROBE    = 10'b00_0000_1000,
    ST_BACK_RD  = 10'b00_0001_0000,
    ST_BACK_CMP = 10'b00_0010_0000,
    ST_SCAN_RD  = 10'b00_0100_0000,
    ST_SCAN_CMP = 10'b00_1000_0000,
    ST_EMIT_RD  = 10'b01_0000_0000,
    ST_EMIT_OUT = 10'b10_0000_0000
  } state_e;

endpackage

// ===== rtl/sorted_table_equal_range_lookup.sv =====
// top level of the sorted table equal-range lookup: record memory and search sequencer
// depends on stel_pkg for stream layout, command codes and state encoding
//
// channel   dir  handshake                   contents
// s_axis    in   s_axis_tvalid_i/tready_o    load record or query key, command in tuser
// m_axis    out  m_axis_tvalid_o/tready_i    one matching record or one miss per transaction
// cfg       in   cfg_we_i                    entry_count, taken on every enabled edge
//
// a load subtracts TABLE_DEPTH from an index at or above it, then writes the record. a query
// makes up to log2(n)+1 binary-search probes, steps back one record at a time to the start of
// the run, scans forward up to MAX_RUN+1 records and re-reads each emitted record, all through
// one memory read port and one key comparator. rst_ni clears the sequencer, out_valid_q and
// entry_count; the record memory is not cleared. a stalled master side holds emission, the next
// transaction is taken once the previous one has handed its last result to the output register.
module sorted_table_equal_range_lookup #(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_RUN     = 64,
  parameter int KEY_BITS    = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write
  input  logic                              cfg_we_i,
  input  logic [stel_pkg::CNTF_W-1:0]       cfg_wdata_i,
  // slave side
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // entry_index, entry_key, entry_link, entry_target, query_key, zero pad
  input  logic [stel_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // command
  input  logic [stel_pkg::IN_TUSER_W-1:0]   s_axis_tuser_i,
  // master side
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // link_kind, linked_title
  output logic [stel_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // found, truncated
  output logic [stel_pkg::OUT_TUSER_W-1:0]  m_axis_tuser_o,
  output logic                              m_axis_tlast_o
);
  import stel_pkg::*;

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = ((AW > CNTF_W) ? AW : CNTF_W) + 1;
  localparam int KB  = (KEY_BITS < KEYF_W) ? KEY_BITS : KEYF_W;
  localparam int RW  = 2 * KB + LINK_W;
  localparam int CNW = $clog2(MAX_RUN + 1);
  localparam logic [CW-1:0]  DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CNW-1:0] RUN_C   = CNW'(MAX_RUN);
  localparam logic [CNW-1:0] ONE_C   = CNW'(1);

  // record memory, key in the low bits, then link, then target
  logic [RW-1:0] mem [TABLE_DEPTH];
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [RW-1:0] rd_data_q;
  logic          wr_en;

  // control registers
  state_e          state_q, state_d;
  logic [CNTF_W-1:0] count_q;
  logic            out_valid_q, out_valid_d;

  // working registers
  logic [CW-1:0]   lo_q, lo_d, hiex_q, hiex_d, first_q, first_d, idx_q, idx_d, n_q, n_d;
  logic [CNW-1:0]  cnt_q, cnt_d;
  logic            trunc_q, trunc_d;
  logic [KB-1:0]   qkey_q, qkey_d;
  logic [RW-1:0]   ld_rec_q, ld_rec_d;

  // output register payload
  logic            found_q, found_d, last_q, last_d, otrunc_q, otrunc_d;
  logic [LINK_W-1:0] link_q, link_d;
  logic [KEYF_W-1:0] title_q, title_d;

  logic            s_fire, out_free;
  logic [CW:0]     mid_sum;
  logic [CW-1:0]   mid, count_ext;
  logic [KB-1:0]   rd_key;
  logic            key_eq, key_lt;

  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // midpoint of the live window, upper bound kept exclusive
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hiex_q} - {{CW{1'b0}}, 1'b1};
  assign mid      = mid_sum[CW:1];
  assign count_ext = CW'(count_q);

  // shared key comparator
  assign rd_key = rd_data_q[KB-1:0];
  assign key_eq = (rd_key == qkey_q);
  assign key_lt = (rd_key < qkey_q);

  // memory write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx_q[AW-1:0]] <= ld_rec_q;
    end
  end

  // memory read port, registered data
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hiex_d      = hiex_q;
    first_d     = first_q;
    idx_d       = idx_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    trunc_d     = trunc_q;
    qkey_d      = qkey_q;
    ld_rec_d    = ld_rec_q;
    found_d     = found_q;
    link_d      = link_q;
    title_d     = title_q;
    last_d      = last_q;
    otrunc_d    = otrunc_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser_i[0] == CMD_LOAD) begin
            idx_d    = CW'(s_axis_tdata_i[IN_IDX_LSB +: IDX_W]);
            ld_rec_d = {s_axis_tdata_i[IN_TARGET_LSB +: KB],
                        s_axis_tdata_i[IN_LINK_LSB +: LINK_W],
                        s_axis_tdata_i[IN_KEY_LSB +: KB]};
            state_d  = ST_LOAD;
          end else begin
            qkey_d  = s_axis_tdata_i[IN_QKEY_LSB +: KB];
            n_d     = (count_ext > DEPTH_C) ? DEPTH_C : count_ext;
            lo_d    = '0;
            hiex_d  = (count_ext > DEPTH_C) ? DEPTH_C : count_ext;
            state_d = ST_SEARCH;
          end
        end
      end
      // fold the index into the table, then write
      ST_LOAD: begin
        if (idx_q >= DEPTH_C) begin
          idx_d = idx_q - DEPTH_C;
        end else begin
          wr_en   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      // issue a probe, or report a miss once the window is empty
      ST_SEARCH: begin
        if (lo_q < hiex_q) begin
          rd_en   = 1'b1;
          rd_addr = mid[AW-1:0];
          first_d = mid;
          state_d = ST_PROBE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = 1'b0;
          link_d      = '0;
          title_d     = '0;
          last_d      = 1'b1;
          otrunc_d    = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      ST_PROBE: begin
        if (key_eq) begin
          state_d = ST_BACK_RD;
        end else if (key_lt) begin
          lo_d    = first_q + CW'(1);
          state_d = ST_SEARCH;
        end else begin
          hiex_d  = first_q;
          state_d = ST_SEARCH;
        end
      end
      // step back to the start of the run
      ST_BACK_RD: begin
        if (first_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = AW'(first_q - CW'(1));
          state_d = ST_BACK_CMP;
        end else begin
          idx_d   = first_q;
          cnt_d   = '0;
          state_d = ST_SCAN_RD;
        end
      end
      ST_BACK_CMP: begin
        if (key_eq) begin
          first_d = first_q - CW'(1);
          state_d = ST_BACK_RD;
        end else begin
          idx_d   = first_q;
          cnt_d   = '0;
          state_d = ST_SCAN_RD;
        end
      end
      // measure the run, one past the limit to detect truncation
      ST_SCAN_RD: begin
        if (idx_q < n_q) begin
          rd_en   = 1'b1;
          rd_addr = idx_q[AW-1:0];
          state_d = ST_SCAN_CMP;
        end else begin
          trunc_d = 1'b0;
          idx_d   = first_q;
          state_d = ST_EMIT_RD;
        end
      end
      ST_SCAN_CMP: begin
        if (key_eq && (cnt_q != RUN_C)) begin
          cnt_d   = cnt_q + ONE_C;
          idx_d   = idx_q + CW'(1);
          state_d = ST_SCAN_RD;
        end else begin
          trunc_d = key_eq;
          idx_d   = first_q;
          state_d = ST_EMIT_RD;
        end
      end
      // re-read each record of the run as the output register frees up
      ST_EMIT_RD: begin
        if (out_free) begin
          rd_en   = 1'b1;
          rd_addr = idx_q[AW-1:0];
          state_d = ST_EMIT_OUT;
        end
      end
      ST_EMIT_OUT: begin
        out_valid_d = 1'b1;
        found_d     = 1'b1;
        link_d      = rd_data_q[KB +: LINK_W];
        title_d     = KEYF_W'(rd_data_q[RW-1 -: KB]);
        last_d      = (cnt_q == ONE_C);
        otrunc_d    = trunc_q;
        cnt_d       = cnt_q - ONE_C;
        idx_d       = idx_q + CW'(1);
        state_d     = (cnt_q == ONE_C) ? ST_IDLE : ST_EMIT_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hiex_q   <= hiex_d;
    first_q  <= first_d;
    idx_q    <= idx_d;
    n_q      <= n_d;
    cnt_q    <= cnt_d;
    trunc_q  <= trunc_d;
    qkey_q   <= qkey_d;
    ld_rec_q <= ld_rec_d;
    found_q  <= found_d;
    link_q   <= link_d;
    title_q  <= title_d;
    last_q   <= last_d;
    otrunc_q <= otrunc_d;
  end

  // ports
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {title_q, link_q};
  assign m_axis_tuser_o  = {otrunc_q, found_q};
  assign m_axis_tlast_o  = last_q;

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the sorted table equal-range lookup: directed table, then random load/query traffic
// predicts most results from a mirror of the record table, checks the master side field by field
// depends on stel_pkg and sorted_table_equal_range_lookup
module tb;
  import stel_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int QUIET_TICKS = 40;
  // leading entries filled with sorted keys, searches never reach past them
  localparam int TBL_FILL    = 160;
  // worst case: every query emitting a full truncated run under heavy stall, several times over
  localparam int LIMIT       = 4_000_000;

  typedef struct packed {
    logic        found;
    logic [7:0]  link_kind;
    logic [23:0] linked_title;
    logic        last;
    logic        truncated;
  } lookup_result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_e;

  typedef struct packed {
    row_kind_e      kind;
    logic [10:0]    num;   // count for a register write, index for a load
    logic [23:0]    key;   // record key for a load, search key for a query
    logic [7:0]     link;
    logic [23:0]    tgt;
    logic           typed;
    lookup_result_t res;
  } dir_row_t;

  localparam lookup_result_t MISS = '{1'b0, 8'h00, 24'h000000, 1'b1, 1'b0};
  localparam lookup_result_t HIT0 = '{1'b1, 8'h00, 24'h000000, 1'b1, 1'b0};
  localparam lookup_result_t NONE = '0;

  // directed stimulus: empty table, extremes, duplicate run, misses, unsorted contents
  dir_row_t dir_tab [0:22] = '{
    '{ROW_QUERY, 11'd0,    24'h000000, 8'h00, 24'h000000, 1'b1, MISS},
    '{ROW_QUERY, 11'd0,    24'hFFFFFF, 8'h00, 24'h000000, 1'b1, MISS},
    '{ROW_LOAD,  11'd0,    24'h000000, 8'h00, 24'h000000, 1'b0, NONE},
    '{ROW_LOAD,  11'd1,    24'h000005, 8'hFF, 24'hFFFFFF, 1'b0, NONE},
    '{ROW_LOAD,  11'd2,    24'h000005, 8'h12, 24'h345678, 1'b0, NONE},
    '{ROW_LOAD,  11'd3,    24'h000005, 8'h81, 24'h800001, 1'b0, NONE},
    '{ROW_LOAD,  11'd4,    24'hFFFFFF, 8'hA5, 24'h5A5A5A, 1'b0, NONE},
    '{ROW_LOAD,  11'd1023, 24'hAAAAAA, 8'h5A, 24'h555555, 1'b0, NONE},
    '{ROW_CFG,   11'd1,    24'h000000, 8'h00, 24'h000000, 1'b0, NONE},
    '{ROW_QUERY, 11'd0,    24'h000000, 8'h00, 24'h000000, 1'b1, HIT0},
    '{ROW_QUERY, 11'd0,    24'h000005, 8'h00, 24'h000000, 1'b1, MISS},
    '{ROW_CFG,   11'd5,    24'h000000, 8'h00, 24'h000000, 1'b0, NONE},
    '{ROW_QUERY, 11'd0,    24'h000000, 8'h00, 24'h000000, 1'b0, NONE},
    '{ROW_QUERY, 11'd0,    24'h000005, 8'h00, 24'h000000, 1'b0, NONE},
    '{ROW_QUERY, 11'd0,    24'hFFFFFF, 8'h00, 24'h000000, 1'b0, NONE},
    '{ROW_QUERY, 11'd0,    24'h000003, 8'h00, 24'h000000, 1'b1, MISS},
    '{ROW_QUERY, 11'd0,    24'hFFFFFE, 8'h00, 24'h000000, 1'b1, MISS},
    '{ROW_QUERY, 11'd0,    24'h000006, 8'h00, 24'h000000, 1'b1, MISS},
    '{ROW_LOAD,  11'd2,    24'h000001, 8'h3C, 24'hC3C3C3, 1'b0, NONE},
    '{ROW_QUERY, 11'd0,    24'h000005, 8'h00, 24'h000000, 1'b0, NONE},
    '{ROW_QUERY, 11'd0,    24'h000001, 8'h00, 24'h000000, 1'b0, NONE},
    '{ROW_CFG,   11'd4,    24'h000000, 8'h00, 24'h000000, 1'b0, NONE},
    '{ROW_QUERY, 11'd0,    24'hFFFFFF, 8'h00, 24'h000000, 1'b1, MISS}
  };

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CNTF_W-1:0]      cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [IN_TUSER_W-1:0]  s_tuser   = '0;
  logic                   m_tready  = 1'b0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [OUT_TUSER_W-1:0] m_axis_tuser_o;
  logic                   m_axis_tlast_o;

  // mirror of the record table and the search count
  logic [23:0]    rec_key   [DEPTH];
  logic [7:0]     rec_link  [DEPTH];
  logic [23:0]    rec_title [DEPTH];
  logic [10:0]    search_count = '0;
  lookup_result_t lookup_results_due [$];

  int err_count      = 0;
  int cycle_cnt      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int loaded_n       = 0;

  sorted_table_equal_range_lookup dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               lookup_results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < 50)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
    err_count++;
  endtask

  // binary search, step back to the run start, emit the run capped at 64
  function automatic void predict_equal_range(input logic [23:0] qk);
    int  n, lo, hi, mid, first, idx, emitted;
    bit  hit, cut;
    lookup_result_t r;
    n   = (search_count > DEPTH) ? DEPTH : int'(search_count);
    lo  = 0;
    hi  = n - 1;
    mid = 0;
    hit = 1'b0;
    while (!hit && hi >= lo) begin
      mid = (lo + hi) / 2;
      if (rec_key[mid] == qk) hit = 1'b1;
      else if (rec_key[mid] < qk) lo = mid + 1;
      else hi = mid - 1;
    end
    if (!hit) begin
      lookup_results_due.push_back(MISS);
      return;
    end
    first = mid;
    while (first > 0 && rec_key[first-1] == qk) first--;
    idx = first;
    emitted = 0;
    while (idx < n && rec_key[idx] == qk && emitted < 64) begin
      emitted++;
      idx++;
    end
    cut = (idx < n) && (rec_key[idx] == qk);
    for (int k = 0; k < emitted; k++) begin
      r.found        = 1'b1;
      r.link_kind    = rec_link[first+k];
      r.linked_title = rec_title[first+k];
      r.last         = (k == emitted - 1);
      r.truncated    = cut;
      lookup_results_due.push_back(r);
    end
  endfunction

  // one slave-side transaction; valid stays high unless the next cycle idles
  task automatic send_item(input logic cmd, input logic [9:0] idx, input logic [23:0] key,
                           input logic [7:0] link, input logic [23:0] tgt,
                           input logic [23:0] qk, input logic typed,
                           input lookup_result_t res);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[IN_IDX_LSB +: IDX_W]     = idx;
    word[IN_KEY_LSB +: KEYF_W]    = key;
    word[IN_LINK_LSB +: LINK_W]   = link;
    word[IN_TARGET_LSB +: KEYF_W] = tgt;
    word[IN_QKEY_LSB +: KEYF_W]   = qk;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (cmd == CMD_LOAD) begin
      rec_key[idx]   = key;
      rec_link[idx]  = link;
      rec_title[idx] = tgt;
    end else if (typed) begin
      lookup_results_due.push_back(res);
    end else begin
      predict_equal_range(qk);
    end
  endtask

  task automatic send_query(input logic [23:0] qk);
    send_item(CMD_QUERY, 10'($urandom), 24'($urandom), 8'($urandom), 24'($urandom), qk,
              1'b0, NONE);
  endtask

  // wait for every pending result, then for the block to go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (lookup_results_due.size() != 0) @(posedge clk_i);
    repeat (QUIET_TICKS) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [10:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    search_count = v;
  endtask

  // fill entries 0..n-1 with ascending keys in runs, two of them long if long_runs is set
  task automatic load_sorted(input int n, input bit long_runs);
    int          run_left, run_no, step;
    logic [23:0] k;
    k        = 24'($urandom_range(0, 3));
    run_left = 0;
    run_no   = 0;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        if (i > 0) begin
          step = $urandom_range(1, 40000);
          if ({8'h00, k} + 32'(step) > 32'h00FF_FFFF) k = 24'hFFFFFF;
          else k = k + 24'(step);
        end
        run_no++;
        if (long_runs && run_no == 2) run_left = 64;
        else if (long_runs && run_no == 4) run_left = 65;
        else if ($urandom_range(7) == 0) run_left = $urandom_range(5, 12);
        else run_left = $urandom_range(1, 4);
      end
      send_item(CMD_LOAD, 10'(i), k, 8'($urandom), 24'($urandom), 24'($urandom), 1'b0, NONE);
      run_left--;
    end
    if (n > loaded_n) loaded_n = n;
  endtask

  // mostly hits on stored keys, some misses, order-keeping rewrites and key noise
  task automatic mix_traffic(input int count);
    int          n_eff, pick, pos;
    logic [23:0] k;
    n_eff = (search_count > DEPTH) ? DEPTH : int'(search_count);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      pos  = $urandom_range(0, loaded_n - 1);
      if (pick < 60) begin
        k = (n_eff == 0) ? 24'($urandom) : rec_key[$urandom_range(0, n_eff - 1)];
        send_query(k);
      end else if (pick < 75) begin
        if (n_eff == 0 || pick < 68) k = 24'($urandom);
        else k = rec_key[$urandom_range(0, n_eff - 1)] + 24'd1;
        send_query(k);
      end else if (pick < 88) begin
        send_item(CMD_LOAD, 10'(pos), rec_key[pos], 8'($urandom), 24'($urandom),
                  24'($urandom), 1'b0, NONE);
      end else begin
        send_item(CMD_LOAD, 10'(pos), 24'($urandom), 8'($urandom), 24'($urandom),
                  24'($urandom), 1'b0, NONE);
      end
    end
  endtask

  // master-side checker
  always @(posedge clk_i) begin : check_results
    lookup_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (lookup_results_due.size() == 0) begin
        report_mismatch("result with none pending, tdata", m_axis_tdata_o, '0);
      end else begin
        want = lookup_results_due.pop_front();
        if (m_axis_tuser_o[0] !== want.found)
          report_mismatch("found", 32'(m_axis_tuser_o[0]), 32'(want.found));
        if (m_axis_tdata_o[7:0] !== want.link_kind)
          report_mismatch("link_kind", 32'(m_axis_tdata_o[7:0]), 32'(want.link_kind));
        if (m_axis_tdata_o[31:8] !== want.linked_title)
          report_mismatch("linked_title", 32'(m_axis_tdata_o[31:8]),
                          32'(want.linked_title));
        if (m_axis_tlast_o !== want.last)
          report_mismatch("last", 32'(m_axis_tlast_o), 32'(want.last));
        if (m_axis_tuser_o[1] !== want.truncated)
          report_mismatch("truncated", 32'(m_axis_tuser_o[1]), 32'(want.truncated));
      end
    end
  end

  // stimulus
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_tab[i]) begin
      case (dir_tab[i].kind)
        ROW_CFG: begin
          write_count(dir_tab[i].num);
        end
        ROW_LOAD: begin
          send_item(CMD_LOAD, dir_tab[i].num[9:0], dir_tab[i].key, dir_tab[i].link,
                    dir_tab[i].tgt, 24'($urandom), 1'b0, NONE);
        end
        default: begin
          send_item(CMD_QUERY, 10'($urandom), 24'($urandom), 8'($urandom), 24'($urandom),
                    dir_tab[i].key, dir_tab[i].typed, dir_tab[i].res);
        end
      endcase
    end

    // filled table with a full-limit run and a truncated run, no idling
    load_sorted(TBL_FILL, 1'b1);
    write_count(11'(TBL_FILL));
    mix_traffic(35);

    // count one short of the fill, sender mostly idle
    settle();
    send_idle_pct  = 87;
    recv_stall_pct = 0;
    write_count(11'(TBL_FILL - 1));
    mix_traffic(25);

    // small table, receiver mostly stalled, then an empty search range
    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 87;
    begin : small_phase
      int n;
      n = $urandom_range(2, 40);
      load_sorted(n, 1'b0);
      write_count(11'(n));
    end
    mix_traffic(20);
    write_count(11'd0);
    mix_traffic(8);

    // both sides idling lightly, single entry then a random count
    settle();
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    write_count(11'd1);
    mix_traffic(10);
    write_count(11'($urandom_range(0, loaded_n)));
    mix_traffic(20);

    settle();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
